### rtl/core/bhrle_pkg.sv
// shared types, constants, the symbol lookup and the run-length step of the binhex text decoder
package bhrle_pkg;

	// run-length marker byte
	localparam logic [7:0] RLE_MARKER = 8'h90;
	// repeat count of a literal byte or a literal marker
	localparam logic [7:0] ONE_COUNT = 8'd1;

	localparam int ALPHA_SIZE  = 64;
	localparam int SYM_W       = 6;
	localparam int MAX_RESULTS = 3;
	localparam int ACCUM_W     = 18;

	// 64-symbol alphabet, symbol value is the index
	localparam logic [7:0] SYM_ALPHABET [ALPHA_SIZE] = '{
		8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h30, 8'h31, 8'h32,
		8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
		8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
		8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51, 8'h52,
		8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5a, 8'h5b,
		8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
		8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h70, 8'h71, 8'h72
	};

	// decoded input word held in the input register
	typedef struct packed {
		logic             sym_ok;
		logic [SYM_W-1:0] sym;
		logic             is_end;
	} in_word_t;

	// one result word
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] repeat_count;
		logic       last_of_item;
		logic       end_of_stream;
	} result_t;

	// load request from the decode core into the output queue
	typedef struct packed {
		logic                          valid;
		logic [1:0]                    n;
		result_t [MAX_RESULTS-1:0]     slots;
	} q_load_t;

	// one step of the run-length decoder
	typedef struct packed {
		logic       emit;
		logic [7:0] data_byte;
		logic [7:0] repeat_count;
		logic       marker_pending;
		logic [7:0] previous_byte;
	} rle_out_t;

	// alphabet lookup: {hit, symbol}
	function automatic logic [SYM_W:0] sym_lookup(input logic [7:0] ch);
		logic [SYM_W:0] r;
		r = '0;
		for (int i = 0; i < ALPHA_SIZE; i++) begin
			if (SYM_ALPHABET[i] == ch) begin
				r = {1'b1, SYM_W'(i)};
			end
		end
		return r;
	endfunction

	// feed one byte through the run-length decoder
	function automatic rle_out_t rle_feed(input logic [7:0] b, input logic mp,
			input logic [7:0] prev);
		rle_out_t o;
		o.emit           = 1'b0;
		o.data_byte      = b;
		o.repeat_count   = ONE_COUNT;
		o.marker_pending = mp;
		o.previous_byte  = prev;
		if (mp) begin
			o.marker_pending = 1'b0;
			if (b == 8'd0) begin
				o.emit          = 1'b1;
				o.data_byte     = RLE_MARKER;
				o.previous_byte = RLE_MARKER;
			end else if (b > 8'd1) begin
				o.emit         = 1'b1;
				o.data_byte    = prev;
				o.repeat_count = 8'(b - 8'd1);
			end
		end else if (b == RLE_MARKER) begin
			o.marker_pending = 1'b1;
		end else begin
			o.emit          = 1'b1;
			o.previous_byte = b;
		end
		return o;
	endfunction

endpackage

### rtl/core/bhrle_in_stage.sv
// input register: alphabet lookup and end detection of each text character
module bhrle_in_stage import bhrle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_char
	input  logic     s_tlast,     // is_end
	input  logic     advance,
	output logic     word_valid_s1,
	output in_word_t word_s1
);

	logic [SYM_W:0] hit;
	logic           accept;

	assign hit      = sym_lookup(s_tdata);
	assign s_tready = !word_valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// valid flag of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_s1 <= 1'b0;
		end else if (accept) begin
			word_valid_s1 <= 1'b1;
		end else if (advance) begin
			word_valid_s1 <= 1'b0;
		end
	end

	// decoded character, zero character also ends the stream
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.sym_ok <= hit[SYM_W];
			word_s1.sym    <= hit[SYM_W-1:0];
			word_s1.is_end <= s_tlast || (s_tdata == 8'd0);
		end
	end

endmodule

### rtl/core/bhrle_core.sv
// symbol grouping, byte split and run-length decode of one input word
module bhrle_core import bhrle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     word_valid_s1,
	input  in_word_t word_s1,
	input  logic     can_load,
	output logic     advance,
	output q_load_t  ld
);

	logic [ACCUM_W-1:0] accum_q;
	logic [1:0]         cnt_q;
	logic [7:0]         prev_q;
	logic               mp_q;

	logic [7:0]         fb [MAX_RESULTS];
	logic [1:0]         nb;
	rle_out_t           st [MAX_RESULTS];
	logic               mp_chain [MAX_RESULTS+1];
	logic [7:0]         prev_chain [MAX_RESULTS+1];
	result_t [MAX_RESULTS-1:0] res;
	logic [1:0]         n;

	// bytes that leave the symbol group for this word
	always_comb begin
		fb[0] = accum_q[ACCUM_W-1 -: 8];
		fb[1] = accum_q[ACCUM_W-9 -: 8];
		fb[2] = {accum_q[1:0], word_s1.sym};
		nb    = 2'd0;
		if (word_s1.is_end) begin
			if (cnt_q == 2'd3) begin
				fb[0] = accum_q[17:10];
				fb[1] = accum_q[9:2];
				nb    = 2'd2;
			end else if (cnt_q == 2'd2) begin
				fb[0] = accum_q[11:4];
				nb    = 2'd1;
			end
		end else if (word_s1.sym_ok && cnt_q == 2'd3) begin
			fb[0] = accum_q[17:10];
			fb[1] = accum_q[9:2];
			nb    = 2'd3;
		end
	end

	// run-length chain and packing of the emitted results
	always_comb begin
		mp_chain[0]   = mp_q;
		prev_chain[0] = prev_q;
		res           = '0;
		n             = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			st[i] = rle_feed(fb[i], mp_chain[i], prev_chain[i]);
			if (2'(i) < nb) begin
				mp_chain[i+1]   = st[i].marker_pending;
				prev_chain[i+1] = st[i].previous_byte;
				if (st[i].emit) begin
					res[n].data_byte    = st[i].data_byte;
					res[n].repeat_count = st[i].repeat_count;
					n = n + 2'd1;
				end
			end else begin
				mp_chain[i+1]   = mp_chain[i];
				prev_chain[i+1] = prev_chain[i];
			end
		end
		// bare end marker when the flush gives nothing
		if (word_s1.is_end && n == 2'd0) begin
			n = 2'd1;
		end
		for (int j = 0; j < MAX_RESULTS; j++) begin
			if (2'(j) + 2'd1 == n) begin
				res[j].last_of_item  = 1'b1;
				res[j].end_of_stream = word_s1.is_end;
			end
		end
	end

	assign advance  = word_valid_s1 && (n == 2'd0 || can_load);
	assign ld.valid = advance && (n != 2'd0);
	assign ld.n     = n;
	assign ld.slots = res;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			cnt_q   <= 2'd0;
			prev_q  <= 8'd0;
			mp_q    <= 1'b0;
		end else if (advance) begin
			if (word_s1.is_end) begin
				accum_q <= '0;
				cnt_q   <= 2'd0;
				prev_q  <= 8'd0;
				mp_q    <= 1'b0;
			end else if (word_s1.sym_ok) begin
				if (cnt_q != 2'd3) begin
					accum_q <= {accum_q[ACCUM_W-SYM_W-1:0], word_s1.sym};
					cnt_q   <= cnt_q + 2'd1;
				end else begin
					accum_q <= '0;
					cnt_q   <= 2'd0;
					prev_q  <= prev_chain[MAX_RESULTS];
					mp_q    <= mp_chain[MAX_RESULTS];
				end
			end
		end
	end

	// an end word leaves the decoder in its reset state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && word_s1.is_end) |=>
		(accum_q == '0 && cnt_q == 2'd0 && prev_q == 8'd0 && !mp_q))
		else $error("decoder state not cleared after end word");

	// an end word always yields at least one result
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && word_s1.is_end) |-> ld.valid)
		else $error("end word produced no result");

endmodule

### rtl/core/bhrle_out_queue.sv
// three-slot result buffer that drains one word per cycle while m_tready is high
module bhrle_out_queue import bhrle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_load_t  ld,
	output logic     can_load,
	output logic     m_tvalid,
	input  logic     m_tready,
	output logic [15:0] m_tdata,  // [7:0] data_byte, [15:8] repeat_count
	output logic     m_tlast,     // last_of_item
	output logic     m_tuser      // end_of_stream
);

	result_t [MAX_RESULTS-1:0] slots_q;
	logic [1:0]                cnt_q;
	logic                      pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;
	assign can_load = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign m_tdata  = {slots_q[0].repeat_count, slots_q[0].data_byte};
	assign m_tlast  = slots_q[0].last_of_item;
	assign m_tuser  = slots_q[0].end_of_stream;

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (ld.valid) begin
			cnt_q <= ld.n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// slot payload, head is slot zero
	always_ff @(posedge clk) begin
		if (ld.valid) begin
			slots_q <= ld.slots;
		end else if (pop) begin
			slots_q[0] <= slots_q[1];
			slots_q[1] <= slots_q[2];
		end
	end

	// a new batch only lands in an empty or emptying buffer
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		ld.valid |-> can_load)
		else $error("result batch loaded over pending results");

	// end of stream is always the last word of its item
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("end of stream word not marked last");

	// only the final word of a batch carries the last flag
	a_last_at_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (cnt_q == 2'd1))
		else $error("last flag seen before the end of a batch");

endmodule

### rtl/core/binhex_ascii_rle_decoder.sv
// top level of the binhex 4.0 text decoder with run-length expansion
//
// Takes one text character per word and returns decoded bytes, each with a
// repeat count, one result word per cycle while m_tready is high. A character
// is accepted every cycle as long as the results of earlier characters drain;
// a character whose group gives k results (k up to three) holds the output
// side until all k have left, as the three-slot result buffer empties through
// the single output port. A character passes the input register and the decode
// logic into the result buffer before its first result. An end word (tlast, or
// a zero character) flushes the pending symbols and always returns at least
// one word, the last marked in tuser; a bare end gives byte 0 with count 0.
module binhex_ascii_rle_decoder import bhrle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_char
	input  logic        s_tlast,   // is_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] repeat_count
	output logic        m_tlast,   // last_of_item
	output logic        m_tuser    // end_of_stream
);

	logic     word_valid_s1;
	in_word_t word_s1;
	logic     advance;
	logic     can_load;
	q_load_t  ld;

	// character lookup register
	bhrle_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.advance       (advance),
		.word_valid_s1 (word_valid_s1),
		.word_s1       (word_s1)
	);

	// grouping and run-length decode
	bhrle_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_valid_s1 (word_valid_s1),
		.word_s1       (word_s1),
		.can_load      (can_load),
		.advance       (advance),
		.ld            (ld)
	);

	// result buffer
	bhrle_out_queue u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### bench/binhex_ascii_rle_decoder_test.sv
// stream test of the binhex text decoder: directed and random text checked against a predictor
`timescale 1ns / 100ps

module binhex_ascii_rle_decoder_test;

	localparam int CYCLE_LIMIT = 300000;
	localparam int QUIET_CYCLES = 20;
	localparam logic [7:0] RUN_MARK = 8'h90;

	// binhex alphabet, symbol value is the index
	localparam logic [7:0] CODE_CHARS [64] = '{
		8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h30, 8'h31, 8'h32,
		8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
		8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
		8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51, 8'h52,
		8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5a, 8'h5b,
		8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
		8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h70, 8'h71, 8'h72
	};

	// one decoded byte run as it leaves the block
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] repeat_count;
		logic       last_of_item;
		logic       end_of_stream;
	} byte_run_t;

	// predicts decoded runs from accepted text and checks the output words
	class binhex_scoreboard;
		logic [17:0] sym_bits;
		logic [1:0]  sym_held;
		logic [7:0]  last_byte;
		logic        run_armed;
		byte_run_t   expected_runs[$];
		int          mismatches;

		function new();
			clear_state();
			mismatches = 0;
		endfunction

		function void clear_state();
			sym_bits  = '0;
			sym_held  = '0;
			last_byte = '0;
			run_armed = 1'b0;
		endfunction

		// run-length stage for one decoded byte
		function void expand_byte(logic [7:0] b);
			if (run_armed) begin
				run_armed = 1'b0;
				if (b == 8'h00) begin
					expected_runs.push_back('{RUN_MARK, 8'd1, 1'b0, 1'b0});
					last_byte = RUN_MARK;
				end else if (b > 8'd1) begin
					expected_runs.push_back('{last_byte, 8'(b - 8'd1), 1'b0, 1'b0});
				end
			end else if (b == RUN_MARK) begin
				run_armed = 1'b1;
			end else begin
				expected_runs.push_back('{b, 8'd1, 1'b0, 1'b0});
				last_byte = b;
			end
		endfunction

		// accepted text word: work out the runs it causes
		function void note_char(logic [7:0] ch, logic is_end);
			int        base;
			int        sym;
			logic [23:0] grp;
			byte_run_t tail;
			base = expected_runs.size();
			sym = -1;
			for (int i = 0; i < 64; i++) begin
				if (CODE_CHARS[i] == ch) sym = i;
			end
			if (is_end || ch == 8'h00) begin
				// flush partial group, drop a waiting marker
				if (sym_held == 2'd3) begin
					expand_byte(sym_bits[17:10]);
					expand_byte(sym_bits[9:2]);
				end else if (sym_held == 2'd2) begin
					expand_byte(sym_bits[11:4]);
				end
				if (expected_runs.size() == base)
					expected_runs.push_back('{8'h00, 8'h00, 1'b0, 1'b0});
				tail = expected_runs.pop_back();
				tail.last_of_item = 1'b1;
				tail.end_of_stream = 1'b1;
				expected_runs.push_back(tail);
				clear_state();
			end else if (sym >= 0) begin
				if (sym_held != 2'd3) begin
					sym_bits = {sym_bits[11:0], 6'(sym)};
					sym_held = sym_held + 2'd1;
				end else begin
					// fourth symbol completes three bytes
					grp = {sym_bits, 6'(sym)};
					sym_bits = '0;
					sym_held = '0;
					expand_byte(grp[23:16]);
					expand_byte(grp[15:8]);
					expand_byte(grp[7:0]);
					if (expected_runs.size() > base) begin
						tail = expected_runs.pop_back();
						tail.last_of_item = 1'b1;
						expected_runs.push_back(tail);
					end
				end
			end
		endfunction

		// accepted output word against the oldest expected run
		function void check_result(logic [7:0] data, logic [7:0] count, logic last, logic eos);
			byte_run_t want;
			byte_run_t got;
			got = '{data, count, last, eos};
			if (expected_runs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: byte %02h count %0d last %0b end %0b",
						data, count, last, eos);
			end else begin
				want = expected_runs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"wrong word: expected byte %02h count %0d last %0b ",
							"end %0b, got byte %02h count %0d last %0b end %0b"},
							want.data_byte, want.repeat_count, want.last_of_item,
							want.end_of_stream, data, count, last, eos);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	binhex_scoreboard sb = new();
	logic calm = 1'b0;
	int   noise_pct = 0;
	int   counted = 0;
	int   cycles = 0;

	binhex_ascii_rle_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output side: check accepted words, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[7:0], m_tdata[15:8], m_tlast, m_tuser);
		m_tready <= calm || ($urandom_range(0, 99) >= 23);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("binhex_ascii_rle_decoder: mismatch");
			$finish;
		end
	end

	// one text word, with random idle cycles ahead of it
	task automatic send_word(input logic [7:0] ch, input logic last);
		while (!calm && $urandom_range(0, 99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_char(ch, last);
		counted++;
	endtask

	// leading symbols of a three-byte group, noise mixed in at random
	task automatic send_symbols(input logic [23:0] grp, input int nsym);
		for (int k = 0; k < nsym; k++) begin
			if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
				send_word(8'($urandom_range(0, 255)), 1'b0);
			send_word(CODE_CHARS[grp[23 - 6 * k -: 6]], 1'b0);
		end
	endtask

	// end of stream, by tlast or by a zero character
	task automatic send_end();
		if ($urandom_range(0, 1) == 1)
			send_word(8'($urandom_range(0, 255)), 1'b1);
		else
			send_word(8'h00, 1'b0);
	endtask

	// byte values weighted toward the run-length codes
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return RUN_MARK;
		if (r < 35) return 8'h00;
		if (r < 45) return 8'h01;
		if (r < 50) return 8'hff;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: bare end, skipped character
		send_word(8'hff, 1'b1);
		send_word(8'h37, 1'b0);
		send_word(8'hff, 1'b0);
		// run before any byte, then a literal
		send_symbols({8'h90, 8'h05, 8'h41}, 4);
		// literal marker, then a marker left waiting
		send_symbols({8'h90, 8'h00, 8'h90}, 4);
		// run of one, full byte, marker waiting again
		send_symbols({8'h01, 8'hff, 8'h90}, 4);
		// three-symbol flush ending on a dropped marker
		send_symbols({8'h02, 8'h90, 8'h3c}, 3);
		send_word(8'hff, 1'b1);
		// two-symbol flush, then one-symbol flush by a zero character
		send_symbols({8'h00, 8'h00, 8'h00}, 2);
		send_word(8'h00, 1'b1);
		send_symbols({8'hc3, 8'h00, 8'h00}, 1);
		send_word(8'h00, 1'b0);
		// longest run
		send_symbols({8'hff, 8'h90, 8'hff}, 4);

		// random: mostly well-formed groups, some flushes and noise
		noise_pct = 5;
		while (counted < 400) begin
			calm = (counted >= 150 && counted < 250);
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_symbols({pick_byte(), pick_byte(), pick_byte()}, 4);
			end else if (pick < 80) begin
				send_symbols({pick_byte(), pick_byte(), pick_byte()}, $urandom_range(1, 3));
				send_end();
			end else if (pick < 88) begin
				send_end();
			end else begin
				repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(1, 255)), 1'b0);
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then a quiet spell for stray words
		while (sb.expected_runs.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_runs.size() == 0)
			$display("binhex_ascii_rle_decoder: match");
		else
			$display("binhex_ascii_rle_decoder: mismatch");
		$finish;
	end

endmodule
